### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on clk_i
// and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TWA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define TWA_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### sv/twa_pkg.sv
package twa_pkg;

  // Field widths.
  localparam int VALUE_W   = 32;
  localparam int TIME_W    = 48;
  localparam int WIN_W     = 27;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Default ring depth.
  localparam int CAPACITY_DEF = 4096;

  // Register reset values.
  localparam logic [WIN_W-1:0]  WINDOW_RST = WIN_W'(60000);
  localparam logic [MODE_W-1:0] MODE_RST   = '0;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd1;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALID   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

  // Aggregate modes.
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CAP_EXCD = 2'd2;

  // One input request.
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [TIME_W-1:0]         sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      unit_changed;
    logic [TIME_W-1:0]         now_ms;
  } twa_in_t;

  // One result request.
  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
  } twa_out_t;

endpackage

### sv/twa_div.sv
module twa_div import twa_pkg::*; #(
  parameter int SUM_W = 44,
  parameter int CNT_W = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SUM_W-1:0]   dividend_i,
  input  logic [CNT_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic signed [VALUE_W-1:0] quotient_o
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    trial;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(SUM_W);
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[SUM_W-2:0], fits};
      rem_d  = fits ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  // Restore the sign; the magnitude of an average always fits the value width.
  assign done_o     = done_q;
  assign quotient_o = neg_q ? VALUE_W'(-quo_q[VALUE_W-1:0]) : quo_q[VALUE_W-1:0];

endmodule

### sv/time_window_aggregator.sv
// A request first expires old entries; a valid sample is then appended and expiry runs again.
// Where a good result is due, the minimum or maximum is found by a scan and the average by the
// serial divider, and the result then goes to the output register.
// Throughput: one request at a time; in_ready_o is high only while idle.
// Reset clears the pointers, count, sum, overflow mark and registers at once;
// the ring memory is left as is and no clearing pass runs.
module time_window_aggregator import twa_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WIN_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  twa_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output twa_out_t             out_data_o
);

  `include "assert_macros.svh"

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = VALUE_W + $clog2(CAPACITY);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_EXP_RD  = 8'b0000_0010,
    ST_EXP_CHK = 8'b0000_0100,
    ST_APPEND  = 8'b0000_1000,
    ST_DECIDE  = 8'b0001_0000,
    ST_SCAN    = 8'b0010_0000,
    ST_DIV     = 8'b0100_0000,
    ST_OUT     = 8'b1000_0000
  } state_e;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    ring_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e                    state_q, state_d;
  logic [WIN_W-1:0]          window_q;
  logic [MODE_W-1:0]         mode_q;
  logic [KIND_W-1:0]         kind_q, kind_d;
  logic [TIME_W-1:0]         t_q, t_d;
  logic [TIME_W-1:0]         now_q, now_d;
  logic signed [VALUE_W-1:0] v_q, v_d;
  logic                      final_q, final_d;
  logic                      any_q, any_d;
  logic [IDX_W-1:0]          oldest_q, oldest_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic [TIME_W:0]           ovf_q, ovf_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [IDX_W-1:0]          scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]          scan_left_q, scan_left_d;
  logic                      scan_vld_q, scan_vld_d;
  logic                      scan_first_q, scan_first_d;
  logic signed [VALUE_W-1:0] best_q, best_d;
  logic signed [VALUE_W-1:0] res_value_q, res_value_d;
  logic [STATUS_W-1:0]       res_status_q, res_status_d;
  logic                      out_valid_q, out_valid_d;
  twa_out_t                  out_q, out_d;

  // Ring storage with one write port and one registered read port.
  logic [TIME_W-1:0]         time_mem_q [CAPACITY];
  logic signed [VALUE_W-1:0] value_mem_q [CAPACITY];
  logic [TIME_W-1:0]         rd_time_q;
  logic signed [VALUE_W-1:0] rd_value_q;
  logic                      mem_we, mem_re;
  logic [IDX_W-1:0]          wr_addr, rd_addr;

  logic [CNT_W:0]            slot_sum;
  logic [IDX_W-1:0]          tail_slot;
  logic [TIME_W:0]           deadline;
  logic                      exp_hit;
  logic                      full;
  logic                      better;
  logic                      div_start, div_done;
  logic signed [VALUE_W-1:0] div_quo;

  // Slot behind the newest entry, with a single wrap correction.
  assign slot_sum  = (CNT_W + 1)'(oldest_q) + (CNT_W + 1)'(count_q);
  assign tail_slot = (slot_sum >= (CNT_W + 1)'(CAPACITY)) ?
                     IDX_W'(slot_sum - (CNT_W + 1)'(CAPACITY)) : IDX_W'(slot_sum);

  // Expiry time of the entry just read.
  assign deadline = {1'b0, rd_time_q} + (TIME_W + 1)'(window_q);
  assign exp_hit  = deadline <= {1'b0, now_q};
  assign full     = count_q == CNT_W'(CAPACITY);
  assign better   = (mode_q == MODE_MIN) ? (rd_value_q < best_q) : (rd_value_q > best_q);

  assign rd_addr  = (state_q == ST_SCAN) ? scan_ptr_q : oldest_q;

  // Sequencer and datapath next state.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    t_d          = t_q;
    now_d        = now_q;
    v_d          = v_q;
    final_d      = final_q;
    any_d        = any_q;
    oldest_d     = oldest_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    sum_d        = sum_q;
    scan_ptr_d   = scan_ptr_q;
    scan_left_d  = scan_left_q;
    scan_vld_d   = scan_vld_q;
    scan_first_d = scan_first_q;
    best_d       = best_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    wr_addr      = tail_slot;
    div_start    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          now_d   = in_data_i.now_ms;
          t_d     = (in_data_i.sample_time == '0) ? in_data_i.now_ms : in_data_i.sample_time;
          v_d     = in_data_i.sample_value;
          final_d = in_data_i.kind != KIND_VALID;
          any_d   = 1'b0;
          // A unit change on a valid sample starts a fresh window.
          if (in_data_i.kind == KIND_VALID && in_data_i.unit_changed) begin
            oldest_d = '0;
            count_d  = '0;
            sum_d    = '0;
            ovf_d    = '0;
          end
          state_d = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        if (count_q == '0) begin
          state_d = final_q ? ST_DECIDE : ST_APPEND;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_EXP_CHK;
        end
      end
      ST_EXP_CHK: begin
        if (exp_hit) begin
          sum_d    = sum_q - SUM_W'(rd_value_q);
          oldest_d = ring_inc(oldest_q);
          count_d  = count_q - 1'b1;
          any_d    = 1'b1;
          state_d  = ST_EXP_RD;
        end else begin
          state_d = final_q ? ST_DECIDE : ST_APPEND;
        end
      end
      ST_APPEND: begin
        // A full ring overwrites its oldest entry, which the last read holds.
        mem_we = 1'b1;
        if (full) begin
          wr_addr  = oldest_q;
          ovf_d    = deadline;
          oldest_d = ring_inc(oldest_q);
          sum_d    = sum_q - SUM_W'(rd_value_q) + SUM_W'(v_q);
        end else begin
          count_d = count_q + 1'b1;
          sum_d   = sum_q + SUM_W'(v_q);
        end
        final_d = 1'b1;
        any_d   = 1'b0;
        state_d = ST_EXP_RD;
      end
      ST_DECIDE: begin
        res_value_d  = '0;
        res_status_d = STATUS_GOOD;
        if (kind_q != KIND_VALID && kind_q != KIND_INVALID && !any_q) begin
          state_d = ST_IDLE;
        end else if (kind_q == KIND_INVALID || count_q == '0) begin
          res_status_d = STATUS_MISSING;
          state_d      = ST_OUT;
        end else if (ovf_q > {1'b0, now_q}) begin
          res_status_d = STATUS_CAP_EXCD;
          state_d      = ST_OUT;
        end else if (mode_q == MODE_MIN || mode_q == MODE_MAX) begin
          scan_ptr_d   = oldest_q;
          scan_left_d  = count_q;
          scan_vld_d   = 1'b0;
          scan_first_d = 1'b1;
          state_d      = ST_SCAN;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_SCAN: begin
        // Reads run one entry ahead of the compare.
        if (scan_left_q != '0) begin
          mem_re      = 1'b1;
          scan_ptr_d  = ring_inc(scan_ptr_q);
          scan_left_d = scan_left_q - 1'b1;
          scan_vld_d  = 1'b1;
        end else begin
          scan_vld_d = 1'b0;
        end
        if (scan_vld_q) begin
          scan_first_d = 1'b0;
          if (scan_first_q || better) begin
            best_d = rd_value_q;
          end
        end
        if (scan_left_q == '0 && !scan_vld_q) begin
          res_value_d = best_q;
          state_d     = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_value_d = div_quo;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_value = res_value_q;
          out_d.status       = res_status_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_q     <= WINDOW_RST;
      mode_q       <= MODE_RST;
      final_q      <= 1'b0;
      any_q        <= 1'b0;
      oldest_q     <= '0;
      count_q      <= '0;
      ovf_q        <= '0;
      sum_q        <= '0;
      scan_left_q  <= '0;
      scan_vld_q   <= 1'b0;
      scan_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      final_q      <= final_d;
      any_q        <= any_d;
      oldest_q     <= oldest_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      sum_q        <= sum_d;
      scan_left_q  <= scan_left_d;
      scan_vld_q   <= scan_vld_d;
      scan_first_q <= scan_first_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_WINDOW) begin
          window_q <= cfg_data_i;
        end else if (cfg_index_i == REG_MODE) begin
          mode_q <= cfg_data_i[MODE_W-1:0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    t_q          <= t_d;
    now_q        <= now_d;
    v_q          <= v_d;
    scan_ptr_q   <= scan_ptr_d;
    best_q       <= best_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  // Ring memory access.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem_q[wr_addr]  <= t_q;
      value_mem_q[wr_addr] <= v_q;
    end
    if (mem_re) begin
      rd_time_q  <= time_mem_q[rd_addr];
      rd_value_q <= value_mem_q[rd_addr];
    end
  end

  // Serial divider for the average.
  twa_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer.
  `TWA_ASSERT_NEVER(a_count_in_range, count_q > CNT_W'(CAPACITY), "entry count above capacity")
  `TWA_ASSERT(a_div_nonzero, (state_q == ST_DIV) |-> (count_q != '0), "average of empty window")
  `TWA_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT), "result not from output state")
  `TWA_ASSERT(a_div_done_in_div, div_done |-> (state_q == ST_DIV), "divider finished outside divide state")

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import twa_pkg::*;

  localparam int unsigned RING_DEPTH   = CAPACITY_DEF;
  localparam int unsigned STALL_LIMIT  = 60000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned REPORT_LIMIT = 10;

  // Codes the package leaves unnamed.
  localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [WIN_W-1:0]          WINDOW_MAX  = WIN_W'(86400000);
  localparam logic [WIN_W-1:0]          WINDOW_ONES = '1;
  localparam logic [TIME_W-1:0]         TIME_MAX    = '1;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;

  logic                 clk;
  logic                 rst_ni;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIN_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  twa_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  twa_out_t             out_data;

  time_window_aggregator #(
    .CAPACITY(RING_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Window state as the block should hold it.
  logic [TIME_W-1:0]         ring_time  [RING_DEPTH];
  logic signed [VALUE_W-1:0] ring_value [RING_DEPTH];
  int unsigned               ring_head;
  int unsigned               ring_count;
  logic [63:0]               overflow_end;
  longint                    window_total;
  logic [WIN_W-1:0]          window_len;
  logic [MODE_W-1:0]         agg_mode;

  twa_out_t    pending_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned config_writes;
  int unsigned mismatch_count;
  int unsigned good_seen;
  int unsigned missing_seen;
  int unsigned capacity_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Remove the oldest stored sample and take it out of the sum.
  function automatic void drop_oldest_sample();
    if (ring_count != 0) begin
      window_total -= longint'(ring_value[ring_head]);
      ring_head = (ring_head + 1) % RING_DEPTH;
      ring_count--;
    end
  endfunction

  // Drop every sample whose time plus the window is at or before now.
  function automatic bit expire_samples(input logic [TIME_W-1:0] now);
    bit removed;
    removed = 1'b0;
    while (ring_count != 0 &&
           64'(ring_time[ring_head]) + 64'(window_len) <= 64'(now)) begin
      drop_oldest_sample();
      removed = 1'b1;
    end
    return removed;
  endfunction

  // Apply one request to the window; returns 1 when it yields a result.
  function automatic bit predict_aggregate(input twa_in_t req, output twa_out_t res);
    logic [TIME_W-1:0] stamp;
    longint            best;
    longint            cand;
    bit                emits;
    int unsigned       pos;
    int unsigned       k;
    stamp = (req.sample_time == '0) ? req.now_ms : req.sample_time;
    emits = 1'b0;
    best = 0;
    res.status = STATUS_GOOD;
    if (req.kind == KIND_VALID) begin
      if (req.unit_changed) begin
        ring_count = 0;
        ring_head = 0;
        window_total = 0;
        overflow_end = '0;
      end
      void'(expire_samples(req.now_ms));
      // A full ring loses its oldest sample and flags the loss for a window.
      if (ring_count >= RING_DEPTH) begin
        overflow_end = 64'(ring_time[ring_head]) + 64'(window_len);
        drop_oldest_sample();
      end
      pos = (ring_head + ring_count) % RING_DEPTH;
      ring_time[pos] = stamp;
      ring_value[pos] = req.sample_value;
      window_total += longint'($signed(req.sample_value));
      ring_count++;
      emits = 1'b1;
    end else if (req.kind == KIND_INVALID) begin
      emits = 1'b1;
    end
    if (expire_samples(req.now_ms)) begin
      emits = 1'b1;
    end

    if (req.kind == KIND_INVALID || ring_count == 0) begin
      res.status = STATUS_MISSING;
    end else if (overflow_end > 64'(req.now_ms)) begin
      res.status = STATUS_CAP_EXCD;
    end else if (agg_mode == MODE_MIN || agg_mode == MODE_MAX) begin
      best = longint'(ring_value[ring_head]);
      for (k = 1; k < ring_count; k++) begin
        cand = longint'(ring_value[(ring_head + k) % RING_DEPTH]);
        if (agg_mode == MODE_MIN ? (cand < best) : (cand > best)) begin
          best = cand;
        end
      end
    end else begin
      best = window_total / longint'(ring_count);
    end
    res.result_value = best[VALUE_W-1:0];
    return emits;
  endfunction

  function automatic twa_in_t make_request(input logic [KIND_W-1:0] kind,
                                           input logic [TIME_W-1:0] stamp,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic unit,
                                           input logic [TIME_W-1:0] now);
    twa_in_t req;
    req.kind = kind;
    req.sample_time = stamp;
    req.sample_value = value;
    req.unit_changed = unit;
    req.now_ms = now;
    return req;
  endfunction

  function automatic void note_mismatch(input string what, input twa_out_t want,
                                        input twa_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected value %0d status %0d, got value %0d status %0d",
               $time, what, $signed(want.result_value), want.status,
               $signed(got.result_value), got.status);
    end
  endfunction

  // Send one request. Called at a falling edge; returns at the falling edge
  // after acceptance with valid still high, so the next caller decides.
  task automatic send_request(input twa_in_t req);
    twa_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_aggregate(req, predicted)) begin
      pending_results.push_back(predicted);
    end
    requests_sent++;
    @(negedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WIN_W-1:0] value);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_index = idx;
    cfg_data = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_WINDOW) begin
      window_len = value;
    end else if (idx == REG_MODE) begin
      agg_mode = value[MODE_W-1:0];
    end
    config_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Requests on an empty window: an invalid sample, a tick and a request of the unused kind.
  task automatic test_empty_window();
    send_request(make_request(KIND_INVALID, '0, '0, 1'b0, 48'd100));
    send_request(make_request(KIND_TICK, '0, '0, 1'b1, 48'd200));
    send_request(make_request(KIND_UNUSED, TIME_MAX, VALUE_MIN, 1'b1, 48'd300));
  endtask

  // Averages, rounding toward zero, unit changes and timestamp corners.
  task automatic test_average_and_timestamps();
    send_request(make_request(KIND_VALID, '0, VALUE_MAX, 1'b0, 48'd1000));
    send_request(make_request(KIND_VALID, 48'd1000, VALUE_MIN, 1'b0, 48'd1000));
    send_request(make_request(KIND_VALID, 48'd1000, -32'sd3, 1'b0, 48'd1000));
    // A unit change on an invalid sample leaves the window alone.
    send_request(make_request(KIND_INVALID, 48'd1500, 32'sd9, 1'b1, 48'd1500));
    send_request(make_request(KIND_VALID, 48'd1200, 32'sd5, 1'b1, 48'd1500));
    send_request(make_request(KIND_TICK, '0, '0, 1'b0, 48'd61200));
    // A sample that is already out of the window leaves again at once.
    send_request(make_request(KIND_VALID, 48'd1, 32'sd7, 1'b0, 48'd100000));
    send_request(make_request(KIND_VALID, TIME_MAX, VALUE_MAX, 1'b0, TIME_MAX));
    send_request(make_request(KIND_TICK, '0, '0, 1'b0, TIME_MAX));
    send_request(make_request(KIND_VALID, '0, -32'sd1, 1'b1, '0));
  endtask

  // Minimum and maximum modes, the unused one, and writes to spare indexes.
  task automatic test_mode_select();
    write_register(REG_MODE, WIN_W'(MODE_MIN));
    send_request(make_request(KIND_VALID, 48'd10, 32'sd10, 1'b0, 48'd10));
    send_request(make_request(KIND_VALID, 48'd20, -32'sd20, 1'b0, 48'd20));
    write_register(REG_MODE, WIN_W'(MODE_MAX));
    send_request(make_request(KIND_VALID, 48'd30, 32'sd30, 1'b0, 48'd30));
    write_register(REG_MODE, WIN_W'(MODE_UNUSED));
    send_request(make_request(KIND_VALID, 48'd40, 32'sd0, 1'b0, 48'd40));
    write_register(REG_SPARE_A, WINDOW_ONES);
    write_register(REG_SPARE_B, WINDOW_ONES);
    send_request(make_request(KIND_VALID, 48'd50, VALUE_MIN, 1'b0, 48'd50));
  endtask

  // Zero, one, all-ones and largest legal window lengths.
  task automatic test_window_extremes();
    write_register(REG_WINDOW, '0);
    send_request(make_request(KIND_VALID, '0, 32'sd4, 1'b1, 48'd5000));
    write_register(REG_WINDOW, WIN_W'(1));
    send_request(make_request(KIND_VALID, 48'd5000, 32'sd6, 1'b1, 48'd5000));
    send_request(make_request(KIND_VALID, 48'd5000, 32'sd8, 1'b0, 48'd5001));
    write_register(REG_WINDOW, WINDOW_ONES);
    send_request(make_request(KIND_VALID, 48'd5001, -32'sd8, 1'b0, 48'd5001));
    write_register(REG_WINDOW, WINDOW_MAX);
    send_request(make_request(KIND_VALID, 48'd5002, 32'sd1, 1'b0, 48'd5002));
  endtask

  // Fill the ring, push past it, then aggregate with ticks as the samples expire.
  task automatic test_ring_overflow();
    logic [TIME_W-1:0]         base_ms;
    logic [TIME_W-1:0]         stamp;
    logic signed [VALUE_W-1:0] value;
    int unsigned               i;
    base_ms = 48'd5000000;
    write_register(REG_WINDOW, WINDOW_MAX);
    write_register(REG_MODE, WIN_W'(MODE_AVG));
    for (i = 0; i < RING_DEPTH; i++) begin
      stamp = base_ms + TIME_W'(i);
      value = $urandom;
      if (i == 17) value = VALUE_MIN;
      if (i == 4000) value = VALUE_MAX;
      send_request(make_request(KIND_VALID, stamp, value, i == 0, stamp));
    end
    // Samples past capacity, one of them invalid.
    for (i = 0; i < 4; i++) begin
      stamp = base_ms + TIME_W'(RING_DEPTH + i);
      send_request(make_request((i == 2) ? KIND_INVALID : KIND_VALID, stamp,
                                VALUE_W'($urandom), 1'b0, stamp));
    end
    write_register(REG_MODE, WIN_W'(MODE_MIN));
    send_request(make_request(KIND_TICK, '0, '0, 1'b0, base_ms + 8 + WINDOW_MAX));
    write_register(REG_MODE, WIN_W'(MODE_MAX));
    send_request(make_request(KIND_TICK, '0, '0, 1'b0, base_ms + 12 + WINDOW_MAX));
    write_register(REG_MODE, WIN_W'(MODE_AVG));
    send_request(make_request(KIND_TICK, '0, '0, 1'b0,
                              base_ms + RING_DEPTH + 100 + WINDOW_MAX));
  endtask

  // Mostly a steady stream of samples and ticks with a moving clock,
  // sprinkled with fully random requests.
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned gap_pct,
                                     input int unsigned stall_pct);
    logic [TIME_W-1:0] clock_ms;
    twa_in_t           req;
    int unsigned       pick;
    int unsigned       i;
    send_idle_pct = gap_pct;
    recv_idle_pct = stall_pct;
    clock_ms = {16'($urandom_range(16'hFFFE)), 32'($urandom)};
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        req.kind = KIND_W'($urandom);
        req.sample_time = {16'($urandom), 32'($urandom)};
        req.sample_value = $urandom;
        req.unit_changed = 1'($urandom_range(1));
        req.now_ms = {16'($urandom), 32'($urandom)};
      end else begin
        if ($urandom_range(9) == 0) begin
          clock_ms += TIME_W'(64'(window_len) * 2 + $urandom_range(50));
        end else begin
          clock_ms += TIME_W'($urandom_range(window_len / 4 + 1));
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
          req.kind = KIND_VALID;
        end else if (pick < 70) begin
          req.kind = KIND_INVALID;
        end else if (pick < 95) begin
          req.kind = KIND_TICK;
        end else begin
          req.kind = KIND_UNUSED;
        end
        req.unit_changed = (req.kind == KIND_VALID) ? ($urandom_range(24) == 0)
                                                    : 1'($urandom_range(1));
        // Timestamps: "now", recent, slightly ahead, or long past.
        pick = $urandom_range(9);
        if (pick < 2) begin
          req.sample_time = '0;
        end else if (pick < 8) begin
          req.sample_time = clock_ms - TIME_W'($urandom_range(window_len / 2));
        end else if (pick == 8) begin
          req.sample_time = clock_ms + TIME_W'($urandom_range(window_len));
        end else begin
          req.sample_time = clock_ms - TIME_W'(64'(window_len) * 2 + $urandom_range(9));
        end
        pick = $urandom_range(19);
        case (pick)
          0:       req.sample_value = VALUE_MAX;
          1:       req.sample_value = VALUE_MIN;
          2:       req.sample_value = -32'sd1;
          default: req.sample_value = $urandom;
        endcase
        req.now_ms = clock_ms;
      end
      send_request(req);
    end
  endtask

  // Receiver side: stall at random at the configured rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : result_check
    twa_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          STATUS_GOOD:    good_seen++;
          STATUS_MISSING: missing_seen++;
          default:        capacity_seen++;
        endcase
        if (out_data.result_value !== want.result_value ||
            out_data.status !== want.status) begin
          note_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  // Ends the run when no request moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[%0t] watchdog: no request moved for %0d cycles, %0d results outstanding",
             $time, STALL_LIMIT, pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WINDOW;
    cfg_data = '0;
    send_idle_pct = 26;
    recv_idle_pct = 53;
    requests_sent = 0;
    results_seen = 0;
    config_writes = 0;
    mismatch_count = 0;
    good_seen = 0;
    missing_seen = 0;
    capacity_seen = 0;
    ring_head = 0;
    ring_count = 0;
    overflow_end = '0;
    window_total = 0;
    window_len = WINDOW_RST;
    agg_mode = MODE_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    test_empty_window();
    test_average_and_timestamps();
    test_mode_select();
    test_window_extremes();

    write_register(REG_WINDOW, WIN_W'(500));
    write_register(REG_MODE, WIN_W'(MODE_AVG));
    test_random_traffic(47, 26, 53);
    write_register(REG_WINDOW, WIN_W'(3000));
    write_register(REG_MODE, WIN_W'(MODE_MIN));
    test_random_traffic(47, 53, 26);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_ring_overflow();

    write_register(REG_WINDOW, WIN_W'(40));
    write_register(REG_MODE, WIN_W'(MODE_MAX));
    test_random_traffic(47, 0, 0);

    // Let the last results drain, then give the block time to go quiet.
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests and %0d register writes; checked %0d results.",
             requests_sent, config_writes, results_seen);
    $display("Results by status: %0d good, %0d missing, %0d over capacity; %0d mismatches.",
             good_seen, missing_seen, capacity_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/twa_pkg.sv
sv/twa_div.sv
sv/time_window_aggregator.sv
sim/testbench.sv
